// ----- rtl/ksct_pkg.sv -----
// Shared types, constants and a helper of the keyed saturating counter table.
package ksct_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int KEY_BYTES   = 32;

    localparam int ENT_W   = $clog2(NUM_ENTRIES);
    localparam int IDX_W   = $clog2(KEY_BYTES);
    localparam int LEN_W   = $clog2(KEY_BYTES + 1);
    localparam int EADDR_W = $clog2(NUM_ENTRIES * KEY_BYTES);
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;
    localparam logic [COUNT_W-1:0] FULL_COUNT_RESET = 8'd50;

    // opcodes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] key_byte;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               table_full;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CMP,
        ST_HIT,
        ST_MISS,
        ST_COPY,
        ST_DONE
    } t_state;

    // flat address of one stored key byte
    function automatic logic [EADDR_W-1:0] ent_addr(input logic [ENT_W-1:0] ent,
                                                   input logic [IDX_W-1:0] idx);
        ent_addr = EADDR_W'(ent) * EADDR_W'(KEY_BYTES) + EADDR_W'(idx);
    endfunction

endpackage

// ----- rtl/ksct_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module ksct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/keyed_saturating_counter_table.sv -----
// Top level of the keyed saturating counter table.
//
// Keys arrive one byte per input beat (opcode key byte) and are counted per key in a
// table of NUM_ENTRIES entries. A key byte, clear or unused opcode beat leaves the
// block ready again at once. An end beat starts a lookup that walks the entries one
// per cycle, pausing for any compare; an active entry whose stored length equals the
// incoming length is then compared byte by byte, one byte per cycle, through the
// registered read ports of the key stores, stopping at the first differing byte. A
// hit ends the walk at that entry; after a miss a new key is copied byte by byte into
// a free entry, if there is one. The result then waits for as long as the previous
// result is still held in the output register. Input is stalled for the lookup; a
// finished result sits in the output register and the block goes back to taking key
// bytes while it waits there. Clear drops all entries as its beat is accepted; stored
// key bytes need no clearing pass because they are read only below a length that has
// been written.
module keyed_saturating_counter_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input beats
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  ksct_pkg::t_in            i_in,
    // result beats
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output ksct_pkg::t_out           o_out,
    // deny-value register write
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [ksct_pkg::COUNT_W-1:0] i_cfg_data
);

    localparam int NE = ksct_pkg::NUM_ENTRIES;

    // control
    ksct_pkg::t_state r_state, n_state;
    logic [ksct_pkg::ENT_W-1:0]   r_ent, n_ent;        // entry under scan
    logic [ksct_pkg::LEN_W-1:0]   r_idx, n_idx;        // next byte index to read
    logic [ksct_pkg::LEN_W-1:0]   r_in_len, n_in_len;  // bytes of incoming key
    logic                         r_free_found, n_free_found;
    logic [ksct_pkg::ENT_W-1:0]   r_free_ent, n_free_ent;

    // entry metadata, kept in flops so clear drops every entry at once
    logic [NE-1:0]                r_active, n_active;
    logic [ksct_pkg::LEN_W-1:0]   r_len [NE];
    logic [ksct_pkg::LEN_W-1:0]   n_len [NE];
    logic [ksct_pkg::COUNT_W-1:0] r_cnt [NE];
    logic [ksct_pkg::COUNT_W-1:0] n_cnt [NE];

    logic [ksct_pkg::COUNT_W-1:0] r_deny;

    // result waiting for the output register, and the output register itself
    ksct_pkg::t_out r_res, n_res;
    ksct_pkg::t_out r_out;
    logic           r_out_valid;
    logic           out_load;

    // key store ports
    logic                          key_we;
    logic [ksct_pkg::IDX_W-1:0]    rd_idx;
    logic [ksct_pkg::BYTE_W-1:0]   key_rdata;
    logic [ksct_pkg::BYTE_W-1:0]   ent_rdata;
    logic                          ent_we;
    logic [ksct_pkg::LEN_W-1:0]    idx_prev;
    logic                          in_acc;
    logic                          last_ent;
    logic                          len_match;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ksct_pkg::ST_IDLE);
    assign last_ent  = (r_ent == ksct_pkg::ENT_W'(NE - 1));
    assign len_match = r_active[r_ent] && (r_len[r_ent] == r_in_len);
    assign idx_prev  = r_idx - ksct_pkg::LEN_W'(1);
    assign key_we    = in_acc && (i_in.opcode == ksct_pkg::OP_KEY)
                       && (r_in_len < ksct_pkg::LEN_W'(ksct_pkg::KEY_BYTES));
    assign ent_we    = (r_state == ksct_pkg::ST_COPY);

    // first byte is fetched while the scan or the miss decision is made
    always_comb begin
        if (r_state == ksct_pkg::ST_SCAN || r_state == ksct_pkg::ST_MISS) begin
            rd_idx = '0;
        end else begin
            rd_idx = r_idx[ksct_pkg::IDX_W-1:0];
        end
    end

    // incoming key bytes
    ksct_ram #(
        .WIDTH (ksct_pkg::BYTE_W),
        .DEPTH (ksct_pkg::KEY_BYTES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_in_len[ksct_pkg::IDX_W-1:0]),
        .i_wdata (i_in.key_byte),
        .i_raddr (rd_idx),
        .o_rdata (key_rdata)
    );

    // stored key bytes, KEY_BYTES slots per entry
    ksct_ram #(
        .WIDTH (ksct_pkg::BYTE_W),
        .DEPTH (ksct_pkg::NUM_ENTRIES * ksct_pkg::KEY_BYTES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ksct_pkg::ent_addr(r_free_ent, idx_prev[ksct_pkg::IDX_W-1:0])),
        .i_wdata (key_rdata),
        .i_raddr (ksct_pkg::ent_addr(r_ent, rd_idx)),
        .o_rdata (ent_rdata)
    );

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_ent        = r_ent;
        n_idx        = r_idx;
        n_in_len     = r_in_len;
        n_free_found = r_free_found;
        n_free_ent   = r_free_ent;
        n_active     = r_active;
        n_len        = r_len;
        n_cnt        = r_cnt;
        n_res        = r_res;
        out_load     = 1'b0;

        unique case (r_state)
            ksct_pkg::ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_in.opcode == ksct_pkg::OP_KEY) begin
                        if (key_we) begin
                            n_in_len = r_in_len + ksct_pkg::LEN_W'(1);
                        end
                    end else if (i_in.opcode == ksct_pkg::OP_END) begin
                        n_ent        = '0;
                        n_free_found = 1'b0;
                        n_state      = ksct_pkg::ST_SCAN;
                    end else if (i_in.opcode == ksct_pkg::OP_CLEAR) begin
                        n_active = '0;
                        for (int e = 0; e < NE; e++) begin
                            n_len[e] = '0;
                            n_cnt[e] = '0;
                        end
                    end else begin
                        // unused opcode: dropped
                    end
                end
            end

            ksct_pkg::ST_SCAN: begin
                if (!r_active[r_ent] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_ent   = r_ent;
                end
                if (len_match && r_in_len == '0) begin
                    n_state = ksct_pkg::ST_HIT;
                end else if (len_match) begin
                    n_idx   = ksct_pkg::LEN_W'(1);
                    n_state = ksct_pkg::ST_CMP;
                end else if (last_ent) begin
                    n_state = ksct_pkg::ST_MISS;
                end else begin
                    n_ent = r_ent + ksct_pkg::ENT_W'(1);
                end
            end

            ksct_pkg::ST_CMP: begin
                // read data is byte r_idx-1; next byte is fetched in parallel
                if (ent_rdata != key_rdata) begin
                    if (last_ent) begin
                        n_state = ksct_pkg::ST_MISS;
                    end else begin
                        n_ent   = r_ent + ksct_pkg::ENT_W'(1);
                        n_state = ksct_pkg::ST_SCAN;
                    end
                end else if (r_idx == r_in_len) begin
                    n_state = ksct_pkg::ST_HIT;
                end else begin
                    n_idx = r_idx + ksct_pkg::LEN_W'(1);
                end
            end

            ksct_pkg::ST_HIT: begin
                if (r_cnt[r_ent] != ksct_pkg::COUNT_MAX) begin
                    n_cnt[r_ent]    = r_cnt[r_ent] + ksct_pkg::COUNT_W'(1);
                    n_res.count     = r_cnt[r_ent] + ksct_pkg::COUNT_W'(1);
                end else begin
                    n_res.count     = r_cnt[r_ent];
                end
                n_res.table_full = 1'b0;
                n_state          = ksct_pkg::ST_DONE;
            end

            ksct_pkg::ST_MISS: begin
                if (!r_free_found) begin
                    n_res.count      = r_deny;
                    n_res.table_full = 1'b1;
                    n_state          = ksct_pkg::ST_DONE;
                end else if (r_in_len == '0) begin
                    n_active[r_free_ent] = 1'b1;
                    n_len[r_free_ent]    = r_in_len;
                    n_cnt[r_free_ent]    = ksct_pkg::COUNT_W'(1);
                    n_res.count          = ksct_pkg::COUNT_W'(1);
                    n_res.table_full     = 1'b0;
                    n_state              = ksct_pkg::ST_DONE;
                end else begin
                    n_idx   = ksct_pkg::LEN_W'(1);
                    n_state = ksct_pkg::ST_COPY;
                end
            end

            ksct_pkg::ST_COPY: begin
                // byte r_idx-1 is written this cycle
                if (r_idx == r_in_len) begin
                    n_active[r_free_ent] = 1'b1;
                    n_len[r_free_ent]    = r_in_len;
                    n_cnt[r_free_ent]    = ksct_pkg::COUNT_W'(1);
                    n_res.count          = ksct_pkg::COUNT_W'(1);
                    n_res.table_full     = 1'b0;
                    n_state              = ksct_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + ksct_pkg::LEN_W'(1);
                end
            end

            ksct_pkg::ST_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_in_len = '0;
                    n_state  = ksct_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ksct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ksct_pkg::ST_IDLE;
            r_in_len    <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_deny      <= ksct_pkg::FULL_COUNT_RESET;
            for (int e = 0; e < NE; e++) begin
                r_len[e] <= '0;
                r_cnt[e] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_in_len <= n_in_len;
            r_active <= n_active;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_deny <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and scan registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_ent        <= n_ent;
        r_idx        <= n_idx;
        r_free_found <= n_free_found;
        r_free_ent   <= n_free_ent;
        r_res        <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/ksct_checker.sv -----
// Port-level assertions for the keyed saturating counter table, with its bind.
module ksct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input ksct_pkg::t_in                i_in,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input ksct_pkg::t_out               o_out
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a counted key never reports zero
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.table_full |-> o_out.count != '0)
        else $error("zero count on a counted key");

    // an end beat always starts a lookup
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.opcode == ksct_pkg::OP_END |=> o_in_stall)
        else $error("no lookup after end beat");

    // key byte and clear beats leave the block ready for the next one
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.opcode == ksct_pkg::OP_KEY || i_in.opcode == ksct_pkg::OP_CLEAR)
        |=> !o_in_stall)
        else $error("stall after key byte or clear beat");

endmodule

bind keyed_saturating_counter_table ksct_checker u_ksct_checker (.*);
